// ===== rtl/contiguous_frame_ring_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous frame ring allocator.
// Each macro places one labeled concurrent assertion, clocked and disabled
// while reset is active.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_FRAME_RING_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FRAME_RING_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfra_pkg.sv =====
// ---------------------------------------------------------------------------
// cfra_pkg
// Shared widths, codes, reset values and types of the frame ring allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package cfra_pkg;

    localparam int OP_W            = 2;
    localparam int REQ_SIZE_W      = 21;
    localparam int STATUS_W        = 3;
    localparam int OUT_OFS_W       = 20;
    localparam int BUF_SIZE_W      = 21;
    localparam int ALIGN_W         = 4;
    // Rounded size: a 21-bit request plus an alignment mask of up to 15 bits.
    localparam int SIZE_W          = 22;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 21;
    localparam int OFFSET_BITS_DEF = 20;

    localparam logic [BUF_SIZE_W-1:0] BUFFER_SIZE_RST = BUF_SIZE_W'(65536);
    localparam logic [ALIGN_W-1:0]    ALIGN_LOG2_RST  = ALIGN_W'(6);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_DISCARD = 2'd1,
        OP_WRAP    = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 3'd0,
        ST_GRANTED_WRAP = 3'd1,
        ST_NO_ROOM      = 3'd2,
        ST_CONSUMED     = 3'd3,
        ST_REJECTED     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_SIZE = 2'd0,
        CFG_ALIGN_LOG2  = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [BUF_SIZE_W-1:0] buffer_size;
        logic [ALIGN_W-1:0]    align_log2;
    } cfra_cfg_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_OFS_W-1:0]  offset;
        logic [OUT_OFS_W-1:0]  marker_offset;
    } cfra_result_t;

endpackage

`default_nettype wire

// ===== rtl/cfra_ifs.sv =====
// ---------------------------------------------------------------------------
// cfra interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfra_req_if;
    import cfra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [REQ_SIZE_W-1:0] req_size;

    modport source (output valid, output op, output req_size, input ready);
    modport sink   (input valid, input op, input req_size, output ready);
endinterface

interface cfra_rsp_if;
    import cfra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_OFS_W-1:0] offset;
    logic [OUT_OFS_W-1:0] marker_offset;

    modport source (output valid, output status, output offset, output marker_offset,
                    input ready);
    modport sink   (input valid, input status, input offset, input marker_offset,
                    output ready);
endinterface

interface cfra_cfg_if;
    import cfra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfra_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// cfra_cfg_regs
// Configuration registers: buffer size and alignment exponent.
// ---------------------------------------------------------------------------
`default_nettype none

module cfra_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cfra_cfg_if.sink           cfg,
    output cfra_pkg::cfra_cfg_t cfg_vals
);
    import cfra_pkg::*;

    logic [BUF_SIZE_W-1:0] buffer_size_reg, buffer_size_next;
    logic [ALIGN_W-1:0]    align_log2_reg, align_log2_next;

    // Writes are always taken; indexes outside the register list are dropped.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        buffer_size_next = buffer_size_reg;
        align_log2_next  = align_log2_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BUFFER_SIZE: buffer_size_next = cfg.data[BUF_SIZE_W-1:0];
                CFG_ALIGN_LOG2:  align_log2_next  = cfg.data[ALIGN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RST;
            align_log2_reg  <= ALIGN_LOG2_RST;
        end
        else
        begin
            buffer_size_reg <= buffer_size_next;
            align_log2_reg  <= align_log2_next;
        end
    end

    assign cfg_vals.buffer_size = buffer_size_reg;
    assign cfg_vals.align_log2  = align_log2_reg;

endmodule

`default_nettype wire

// ===== rtl/cfra_decide.sv =====
// ---------------------------------------------------------------------------
// cfra_decide
// Combinational decision for one item: rounds the size, checks for room or
// overrun, and forms the result and the next read and write offsets.
// ---------------------------------------------------------------------------
`default_nettype none

module cfra_decide #(
    parameter int OFFSET_BITS = cfra_pkg::OFFSET_BITS_DEF
) (
    input  wire logic [cfra_pkg::OP_W-1:0]       op,
    input  wire logic [cfra_pkg::REQ_SIZE_W-1:0] req_size,
    input  wire cfra_pkg::cfra_cfg_t             cfg_vals,
    input  wire logic [OFFSET_BITS-1:0]          read_offset,
    input  wire logic [OFFSET_BITS-1:0]          write_offset,
    output cfra_pkg::cfra_result_t               result,
    output logic [OFFSET_BITS-1:0]               read_offset_next,
    output logic [OFFSET_BITS-1:0]               write_offset_next
);
    import cfra_pkg::*;

    // Wide enough for any offset plus any rounded size without overflow.
    localparam int CALC_W = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 2;

    logic [SIZE_W-1:0]      amask;
    logic [SIZE_W-1:0]      sz;
    logic [CALC_W-1:0]      r_x, w_x, sz_x, bs_x;
    logic [CALC_W-1:0]      gap, free1, adv_w, adv_r;
    logic [OFFSET_BITS-1:0] w_after, r_after, wrap_after;

    always_comb
    begin
        amask = ~({SIZE_W{1'b1}} << cfg_vals.align_log2);
        sz    = (SIZE_W'(req_size) + amask) & ~amask;

        r_x  = CALC_W'(read_offset);
        w_x  = CALC_W'(write_offset);
        sz_x = CALC_W'(sz);
        bs_x = CALC_W'(cfg_vals.buffer_size);

        gap   = r_x - w_x;
        free1 = (bs_x > w_x) ? (bs_x - w_x) : '0;
        adv_w = w_x + sz_x;
        adv_r = r_x + sz_x;

        // An offset that lands exactly on the buffer end wraps to zero.
        w_after    = (adv_w == bs_x) ? '0 : adv_w[OFFSET_BITS-1:0];
        r_after    = (adv_r == bs_x) ? '0 : adv_r[OFFSET_BITS-1:0];
        wrap_after = (sz_x == bs_x)  ? '0 : sz_x[OFFSET_BITS-1:0];
    end

    always_comb
    begin
        result.status        = ST_REJECTED;
        result.offset        = OUT_OFS_W'(r_x);
        result.marker_offset = '0;
        read_offset_next     = read_offset;
        write_offset_next    = write_offset;

        unique case (op)
            OP_ALLOC:
            begin
                priority if ((r_x > w_x) && (sz_x < gap))
                begin
                    result.status     = ST_GRANTED;
                    result.offset     = OUT_OFS_W'(w_x);
                    write_offset_next = w_after;
                end
                else if (r_x > w_x)
                begin
                    result.status = ST_NO_ROOM;
                    result.offset = '0;
                end
                else if (sz_x < free1)
                begin
                    result.status     = ST_GRANTED;
                    result.offset     = OUT_OFS_W'(w_x);
                    write_offset_next = w_after;
                end
                else if (sz_x < r_x)
                begin
                    // Frame goes to the start; a wrap marker sits at the old offset.
                    result.status        = ST_GRANTED_WRAP;
                    result.offset        = '0;
                    result.marker_offset = OUT_OFS_W'(w_x);
                    write_offset_next    = wrap_after;
                end
                else
                begin
                    result.status = ST_NO_ROOM;
                    result.offset = '0;
                end
            end
            OP_DISCARD:
            begin
                if (adv_r <= bs_x)
                begin
                    result.status    = ST_CONSUMED;
                    result.offset    = OUT_OFS_W'(CALC_W'(r_after));
                    read_offset_next = r_after;
                end
            end
            OP_WRAP:
            begin
                result.status    = ST_CONSUMED;
                result.offset    = '0;
                read_offset_next = '0;
            end
            default:
            begin
                // Undefined operation code: rejected, state held.
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/contiguous_frame_ring_allocator.sv =====
// An accepted item is decided as it moves to the result register.
// Throughput: one item per cycle while results are taken; the decision for an
// item is a few adds and compares on the two offset registers between the input
// and result registers. The input register refills while a finished result
// waits to be taken. Reset (rst_n, asynchronous, active low) clears both
// offsets and valid flags and restores buffer_size to 65536, align_log2 to 6.
// ---------------------------------------------------------------------------
// contiguous_frame_ring_allocator
// Top level: input register, offset state, decision logic, result register
// and configuration registers of the contiguous frame ring allocator.
// ---------------------------------------------------------------------------
`default_nettype none

`include "contiguous_frame_ring_allocator_assert.svh"

module contiguous_frame_ring_allocator #(
    parameter int OFFSET_BITS = cfra_pkg::OFFSET_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cfra_cfg_if.sink  cfg,
    cfra_req_if.sink  req,
    cfra_rsp_if.source rsp
);
    import cfra_pkg::*;

    // Input register. An item waits here until the result register is free;
    // the offsets it is judged against always include every earlier item,
    // because the offsets are updated in the same cycle an item moves on.
    logic                  in_valid_reg, in_valid_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [REQ_SIZE_W-1:0] req_size_reg, req_size_next;

    // Result register, which holds a finished item until it is taken.
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [OUT_OFS_W-1:0] out_offset_reg, out_offset_next;
    logic [OUT_OFS_W-1:0] out_marker_reg, out_marker_next;

    // Ring state.
    logic [OFFSET_BITS-1:0] read_offset_reg, read_offset_next;
    logic [OFFSET_BITS-1:0] write_offset_reg, write_offset_next;
    logic [OFFSET_BITS-1:0] dec_read_offset, dec_write_offset;

    cfra_cfg_t    cfg_vals;
    cfra_result_t dec_result;

    logic accept;
    logic move;

    cfra_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    cfra_decide #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decide (
        .op                (op_reg),
        .req_size          (req_size_reg),
        .cfg_vals          (cfg_vals),
        .read_offset       (read_offset_reg),
        .write_offset      (write_offset_reg),
        .result            (dec_result),
        .read_offset_next  (dec_read_offset),
        .write_offset_next (dec_write_offset)
    );

    // The held item moves to the result register whenever that register is
    // empty or is being emptied in this cycle.
    assign move      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || move;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = (in_valid_reg && !move) || accept;
        op_next       = accept ? req.op : op_reg;
        req_size_next = accept ? req.req_size : req_size_reg;

        out_valid_next  = move || (out_valid_reg && !rsp.ready);
        out_status_next = move ? dec_result.status : out_status_reg;
        out_offset_next = move ? dec_result.offset : out_offset_reg;
        out_marker_next = move ? dec_result.marker_offset : out_marker_reg;

        read_offset_next  = move ? dec_read_offset : read_offset_reg;
        write_offset_next = move ? dec_write_offset : write_offset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            read_offset_reg  <= '0;
            write_offset_reg <= '0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            read_offset_reg  <= read_offset_next;
            write_offset_reg <= write_offset_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_size_reg   <= req_size_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_marker_reg <= out_marker_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.offset        = out_offset_reg;
    assign rsp.marker_offset = out_marker_reg;

    // The offsets change only when an item is decided.
    `CFRA_ASSERT_NEXT(a_state_only_on_move, clk, rst_n, !move,
        $stable(read_offset_reg) && $stable(write_offset_reg),
        "ring offsets changed with no item decided")

    // Only an allocation may move the write offset.
    `CFRA_ASSERT_NEXT(a_write_only_alloc, clk, rst_n, move && (op_reg != OP_ALLOC),
        $stable(write_offset_reg), "write offset moved on a non-allocate item")

    // Allocations never move the read offset.
    `CFRA_ASSERT_NEXT(a_read_not_alloc, clk, rst_n, move && (op_reg == OP_ALLOC),
        $stable(read_offset_reg), "read offset moved on an allocate item")

    // A full input register behind a stalled result takes no new item.
    `CFRA_ASSERT_SAME(a_no_accept_when_full, clk, rst_n,
        in_valid_reg && out_valid_reg && !rsp.ready, !req.ready,
        "request taken while both registers are full")

endmodule

`default_nettype wire

// ===== tb/contiguous_frame_ring_allocator_checker.sv =====
// ---------------------------------------------------------------------------
// Frame ring allocator checker
// Watches the configuration, request and result channels, keeps its own copy
// of the ring offsets and settings, works out the result of every accepted
// request and compares each accepted result with the oldest one outstanding.
// ---------------------------------------------------------------------------
module contiguous_frame_ring_allocator_checker #(
    parameter int OFFSET_BITS = cfra_pkg::OFFSET_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfra_cfg_if        cfg,
    cfra_req_if        req,
    cfra_rsp_if        rsp,
    output int         errors,
    output int         pending,
    output int         granted_count,
    output int         wrapped_count,
    output int         no_room_count,
    output int         consumed_count,
    output int         rejected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfra_pkg::*;

    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] OFS_MASK    = (64'd1 << OFFSET_BITS) - 64'd1;

    logic [63:0]  ring_bytes;
    logic [3:0]   align_shift;
    logic [63:0]  rd_ofs;
    logic [63:0]  wr_ofs;
    cfra_result_t frame_results_q[$];

    // Moves an offset forward; landing exactly on the ring end means offset 0.
    function automatic logic [63:0] advance_offset(input logic [63:0] base,
                                                   input logic [63:0] amount);
        logic [63:0] next;
        next = base + amount;
        if (next == ring_bytes)
            next = '0;
        return next & OFS_MASK;
    endfunction

    // Decides one request against the current offsets and updates them.
    function automatic cfra_result_t decide_request(input logic [OP_W-1:0]       op,
                                                    input logic [REQ_SIZE_W-1:0] req_size);
        logic [63:0]  amask;
        logic [63:0]  size;
        logic [63:0]  r;
        logic [63:0]  w;
        logic [63:0]  tail_room;
        cfra_result_t res;
        amask             = (64'd1 << align_shift) - 64'd1;
        size              = (64'(req_size) + amask) & ~amask;
        r                 = rd_ofs;
        w                 = wr_ofs;
        res.status        = ST_REJECTED;
        res.offset        = r[OUT_OFS_W-1:0];
        res.marker_offset = '0;
        case (op)
            OP_ALLOC:
            begin
                if (r > w)
                begin
                    // The reader is ahead: only the gap up to it is usable.
                    if (size < r - w)
                    begin
                        res.status = ST_GRANTED;
                        res.offset = w[OUT_OFS_W-1:0];
                        wr_ofs     = advance_offset(w, size);
                    end
                    else
                    begin
                        res.status = ST_NO_ROOM;
                        res.offset = '0;
                    end
                end
                else
                begin
                    tail_room = (ring_bytes > w) ? ring_bytes - w : 64'd0;
                    if (size < tail_room)
                    begin
                        res.status = ST_GRANTED;
                        res.offset = w[OUT_OFS_W-1:0];
                        wr_ofs     = advance_offset(w, size);
                    end
                    else if (size < r)
                    begin
                        res.status        = ST_GRANTED_WRAP;
                        res.offset        = '0;
                        res.marker_offset = w[OUT_OFS_W-1:0];
                        wr_ofs            = advance_offset(64'd0, size);
                    end
                    else
                    begin
                        res.status = ST_NO_ROOM;
                        res.offset = '0;
                    end
                end
            end
            OP_DISCARD:
            begin
                if (r + size <= ring_bytes)
                begin
                    rd_ofs     = advance_offset(r, size);
                    res.status = ST_CONSUMED;
                    res.offset = rd_ofs[OUT_OFS_W-1:0];
                end
            end
            OP_WRAP:
            begin
                rd_ofs     = '0;
                res.status = ST_CONSUMED;
                res.offset = '0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cfra_result_t frame_res;
        if (!rst_n)
        begin
            ring_bytes  = 64'(BUFFER_SIZE_RST);
            align_shift = ALIGN_LOG2_RST;
            rd_ofs      = '0;
            wr_ofs      = '0;
            frame_results_q.delete();
            errors         <= 0;
            pending        <= 0;
            granted_count  <= 0;
            wrapped_count  <= 0;
            no_room_count  <= 0;
            consumed_count <= 0;
            rejected_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_BUFFER_SIZE: ring_bytes  = 64'(cfg.data);
                    CFG_ALIGN_LOG2:  align_shift = cfg.data[ALIGN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Results are compared before this edge's request is predicted, so a
            // result can never be matched against an item accepted at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result with none outstanding: st %0d ofs 0x%0h mk 0x%0h",
                                 $realtime, rsp.status, rsp.offset, rsp.marker_offset);
                    errors <= errors + 1;
                end
                else
                begin
                    frame_res = frame_results_q.pop_front();
                    if (rsp.status !== frame_res.status || rsp.offset !== frame_res.offset ||
                        rsp.marker_offset !== frame_res.marker_offset)
                    begin
                        if (errors < MAX_REPORTS)
                            $display({"%0t: mismatch: expected st %0d ofs 0x%0h mk 0x%0h, ",
                                      "got st %0d ofs 0x%0h mk 0x%0h"},
                                     $realtime, frame_res.status, frame_res.offset,
                                     frame_res.marker_offset, rsp.status, rsp.offset,
                                     rsp.marker_offset);
                        errors <= errors + 1;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                frame_res = decide_request(req.op, req.req_size);
                frame_results_q.push_back(frame_res);
                case (frame_res.status)
                    ST_GRANTED:      granted_count  <= granted_count + 1;
                    ST_GRANTED_WRAP: wrapped_count  <= wrapped_count + 1;
                    ST_NO_ROOM:      no_room_count  <= no_room_count + 1;
                    ST_CONSUMED:     consumed_count <= consumed_count + 1;
                    default:         rejected_count <= rejected_count + 1;
                endcase
            end

            pending <= frame_results_q.size();
        end
    end

endmodule

// ===== tb/contiguous_frame_ring_allocator_test.sv =====
// ---------------------------------------------------------------------------
// Frame ring allocator test
// Drives allocate, discard, wrap and undefined ops into the allocator across
// ring sizes and alignments, with random gaps on both handshakes and one long
// result hold-off; the checker beside the block predicts every result.
// ---------------------------------------------------------------------------
module contiguous_frame_ring_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfra_pkg::*;

    localparam int RESET_CYCLES    = 7;
    // No handshake at all for this many cycles means the block has hung. The
    // longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int PHASE_ITEMS     = 114;

    // The op field is two bits wide but only three codes are defined; the
    // fourth must be refused.
    localparam logic [OP_W-1:0]       OP_UNDEFINED = 2'd3;
    localparam logic [REQ_SIZE_W-1:0] MAX_REQ_SIZE = {REQ_SIZE_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int granted_count;
    int wrapped_count;
    int no_room_count;
    int consumed_count;
    int rejected_count;

    int          idle_cycles = 0;
    int          results_seen = 0;
    bit          held_off = 1'b0;
    bit          sender_steady = 1'b0;
    int unsigned cur_ring_bytes;

    // Sizes of recent allocation requests, so that most discards release a frame of
    // a size that was asked for, as a real consumer would.
    logic [REQ_SIZE_W-1:0] alloc_history[$];

    cfra_cfg_if cfg_ch ();
    cfra_req_if req_ch ();
    cfra_rsp_if rsp_ch ();

    contiguous_frame_ring_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    contiguous_frame_ring_allocator_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .errors         (errors),
        .pending        (pending),
        .granted_count  (granted_count),
        .wrapped_count  (wrapped_count),
        .no_room_count  (no_room_count),
        .consumed_count (consumed_count),
        .rejected_count (rejected_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle stretch lengths come from two ranges, the shorter one most of the time.
    function automatic int unsigned gap_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // Frame sizes are drawn relative to the ring currently configured, mostly
    // small so that many frames are live at once and the offsets wrap often.
    function automatic logic [REQ_SIZE_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return REQ_SIZE_W'($urandom_range(0, cur_ring_bytes / 8));
        else if (roll < 95)
            return REQ_SIZE_W'($urandom_range(0, cur_ring_bytes / 2));
        else
            return REQ_SIZE_W'($urandom_range(0, cur_ring_bytes));
    endfunction

    // Offers one item and returns at the edge where it is accepted, or after the gap
    // that may follow. Valid stays high unless a gap follows, so back-to-back items
    // never lower and raise it in the same time step.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_SIZE_W-1:0] size);
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.req_size <= size;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (!sender_steady && $urandom_range(0, 99) < 40)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering items and waits until every outstanding result has been
    // taken, then lets the result register settle.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Settings change only with the block idle. The offsets carry over, so a
    // smaller ring can leave them at or past its end.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] ring, input logic [ALIGN_W-1:0] shift);
        drain_results();
        write_register(CFG_BUFFER_SIZE, ring);
        write_register(CFG_ALIGN_LOG2, CFG_DATA_W'(shift));
        cfg_ch.valid <= 1'b0;
        cur_ring_bytes = 32'(ring);
    endtask

    // Random traffic: mostly allocations and discards that follow them, some
    // consumer wrap notices, and a little noise with undefined ops and sizes
    // spanning the whole field.
    task automatic run_traffic(input int items);
        int unsigned           roll;
        logic [REQ_SIZE_W-1:0] size;
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                size = pick_size();
                alloc_history.push_back(size);
                if (alloc_history.size() > 32)
                    void'(alloc_history.pop_front());
                send_request(OP_ALLOC, size);
            end
            else if (roll < 80)
            begin
                if (alloc_history.size() != 0 && $urandom_range(0, 99) < 70)
                    size = alloc_history.pop_front();
                else
                    size = pick_size();
                send_request(OP_DISCARD, size);
            end
            else if (roll < 88)
                send_request(OP_WRAP, REQ_SIZE_W'($urandom_range(0, MAX_REQ_SIZE)));
            else if (roll < 92)
                send_request(OP_UNDEFINED, REQ_SIZE_W'($urandom_range(0, MAX_REQ_SIZE)));
            else
                send_request(roll[0] ? OP_ALLOC : OP_DISCARD,
                             REQ_SIZE_W'($urandom_range(0, MAX_REQ_SIZE)));
        end
    endtask

    // Result side: random stalls with steady stretches in between, and once,
    // after enough results, a long hold-off while items are still being
    // offered so that the block fills and stops taking input.
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned cycle_no;
        bit          steady;
        stall_left = 0;
        cycle_no   = 0;
        steady     = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (!held_off && results_seen >= HOLD_OFF_AFTER && req_ch.valid)
            begin
                held_off = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    stall_left = gap_length();
            end
        end
    end

    // Watchdog: counts cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
                results_seen <= results_seen + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no handshake for %0d cycles, giving up", WATCHDOG_LIMIT);
                $display("contiguous_frame_ring_allocator_test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_ALLOC;
        req_ch.req_size <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_BUFFER_SIZE;
        cfg_ch.data     <= '0;
        cur_ring_bytes = 32'(BUFFER_SIZE_RST);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence under the reset settings: 65536-byte ring, 64-byte
        // alignment. The comments give the offsets that each step should leave.
        send_request(OP_ALLOC, '0);            // zero size: granted, write stays at 0
        send_request(OP_ALLOC, 21'd1);         // rounds up to 64, write at 64
        send_request(OP_ALLOC, 21'd100);       // rounds up to 128, write at 192
        send_request(OP_DISCARD, 21'd1);       // read moves to 64
        send_request(OP_ALLOC, 21'd65300);     // exactly the tail room: refused, no room
        send_request(OP_ALLOC, 21'd65200);     // fits before the end, write at 65408
        send_request(OP_DISCARD, 21'd128);     // read moves to 192
        send_request(OP_ALLOC, 21'd100);       // tail too short: granted at 0 with a wrap marker
        send_request(OP_ALLOC, '0);            // reader ahead, zero size still fits
        send_request(OP_ALLOC, 21'd64);        // gap to the reader is exactly 64: no room
        send_request(OP_DISCARD, 21'd65280);   // read advances to 65472
        send_request(OP_DISCARD, 21'd64);      // read reaches the ring end and wraps to 0
        send_request(OP_WRAP, MAX_REQ_SIZE);   // consumer wrap notice, size ignored
        send_request(OP_UNDEFINED, '0);        // undefined op: rejected
        send_request(OP_DISCARD, MAX_REQ_SIZE);// discard past the ring end: rejected
        send_request(OP_ALLOC, MAX_REQ_SIZE);  // largest request rounds beyond the ring
        send_request(OP_DISCARD, '0);          // zero discard leaves the reader in place
        send_request(OP_ALLOC, 21'd1048575);   // larger than the ring: no room

        // Random phases through the extremes and a spread of settings. Going
        // from the largest ring straight to the smallest can leave the offsets
        // past the new end.
        reconfigure(21'd1048576, 4'd12);
        sender_steady = 1'b1;
        run_traffic(PHASE_ITEMS);
        reconfigure(21'd64, 4'd3);
        sender_steady = 1'b0;
        run_traffic(PHASE_ITEMS);
        reconfigure(21'd4096, 4'd3);
        sender_steady = 1'b1;
        run_traffic(PHASE_ITEMS);
        reconfigure(21'd1024, 4'd4);
        sender_steady = 1'b0;
        run_traffic(PHASE_ITEMS);
        reconfigure(21'd65536, 4'd9);
        run_traffic(PHASE_ITEMS);
        reconfigure(21'd2048, 4'd6);
        sender_steady = 1'b1;
        run_traffic(PHASE_ITEMS);

        drain_results();

        $display("results: %0d granted, %0d granted after a wrap, %0d no room, %0d consumed, %0d rejected",
                 granted_count, wrapped_count, no_room_count, consumed_count,
                 rejected_count);
        $display("rings of 64 to 1048576 bytes, alignments of 8 to 4096; long hold-off %s",
                 held_off ? "applied" : "not reached");
        if (errors == 0 && pending == 0)
            $display("contiguous_frame_ring_allocator_test passed");
        else
            $display("contiguous_frame_ring_allocator_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfra_pkg.sv
rtl/cfra_ifs.sv
rtl/cfra_cfg_regs.sv
rtl/cfra_decide.sv
rtl/contiguous_frame_ring_allocator.sv
tb/contiguous_frame_ring_allocator_checker.sv
tb/contiguous_frame_ring_allocator_test.sv
